// ----- rtl/wts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

	localparam int CHANNELS  = 16;
	localparam int MEM_BYTES = 2048;

	localparam int ACTION_W = 2;
	localparam int ADDR_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 24;
	localparam int VOL_W    = 7;
	localparam int CFG_IDX_W = 1;

	// signed width of one panned channel contribution and of the frame mix
	localparam int CONTRIB_W = 14;
	localparam int MIX_W     = 20;

	// reciprocal for truncating division by 100, exact for inputs below 2**30
	localparam int          DIV_IN_W  = 27;
	localparam int          DIV_OUT_W = 21;
	localparam logic [26:0] DIV100_K  = 27'd85899346;

	localparam logic [15:0] PAGE_ADDR    = 16'hfcff;
	localparam logic [3:0]  PAGE_SEL_HI  = 4'h3;
	localparam logic [7:0]  WINDOW_HI    = 8'hfd;
	localparam logic [7:0]  AMP_MAX      = 8'h80;
	localparam int          SET_BASE     = 'h700;
	localparam logic [6:0]  VOLUME_RESET = 7'd100;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [0:0] {
		CFG_ENABLE = 1'b0,
		CFG_VOLUME = 1'b1
	} cfg_index_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_FETCH,
		S_PHASE,
		S_DATA,
		S_VOICE,
		S_FIN1,
		S_FIN2,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [7:0]  data;
		logic [7:0]  amp;
		logic [7:0]  ctrl;
	} voice_req_t;

	typedef struct packed {
		logic                        done;
		logic signed [CONTRIB_W-1:0] left;
		logic signed [CONTRIB_W-1:0] right;
	} voice_rsp_t;

	// dac law, segment base and step
	function automatic logic [12:0] dac_base(input logic [2:0] seg);
		logic [12:0] v;
		unique case (seg)
			3'd0: v = 13'd0;
			3'd1: v = 13'd33;
			3'd2: v = 13'd99;
			3'd3: v = 13'd231;
			3'd4: v = 13'd495;
			3'd5: v = 13'd1023;
			3'd6: v = 13'd2079;
			3'd7: v = 13'd4191;
		endcase
		return v;
	endfunction

	function automatic logic [8:0] dac_inc(input logic [2:0] seg);
		return 9'(9'd2 << seg);
	endfunction

	function automatic logic [6:0] pan_left(input logic [3:0] pos);
		logic [6:0] v;
		unique case (pos)
			4'd8, 4'd9, 4'd10: v = 7'd100;
			4'd11:             v = 7'd83;
			4'd12:             v = 7'd67;
			4'd13:             v = 7'd50;
			4'd14:             v = 7'd33;
			4'd15:             v = 7'd17;
			default:           v = 7'd0;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] pan_right(input logic [3:0] pos);
		logic [6:0] v;
		unique case (pos)
			4'd8, 4'd9, 4'd10: v = 7'd0;
			4'd11:             v = 7'd17;
			4'd12:             v = 7'd33;
			4'd13:             v = 7'd50;
			4'd14:             v = 7'd67;
			4'd15:             v = 7'd83;
			default:           v = 7'd100;
		endcase
		return v;
	endfunction

	function automatic logic [DIV_OUT_W-1:0] div100(input logic [DIV_IN_W-1:0] m);
		logic [53:0] p;
		p = 54'(m) * 54'(DIV100_K);
		return p[53:33];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/wts_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wts_cmd_if import wts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ADDR_W-1:0]   address;
	logic [BYTE_W-1:0]   write_data;

	modport source (output valid, action, address, write_data, input ready);
	modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface wts_rsp_if import wts_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [BYTE_W-1:0]          read_data;
	logic                       read_hit;
	logic                       frame_valid;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;

	modport source (output valid, read_data, read_hit, frame_valid, left_out, right_out,
		input ready);
	modport sink   (input valid, read_data, read_hit, frame_valid, left_out, right_out,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/wts_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/wts_voice.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wts_voice import wts_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire voice_req_t req,
	output voice_rsp_t      rsp
);

	logic                        v_s1, v_s2, v_s3, v_s4;
	logic [6:0]                  level_s1;
	logic                        neg_s1, neg_s2, neg_s3;
	logic [3:0]                  pan_s1, pan_s2;
	logic [12:0]                 mag_s2;
	logic [19:0]                 pl_s3, pr_s3;
	logic signed [CONTRIB_W-1:0] left_s4, right_s4;

	logic [7:0]           amp_cap;
	logic [14:0]          scaled;
	logic [DIV_OUT_W-1:0] ql, qr;

	always_comb begin
		amp_cap = (req.amp > AMP_MAX) ? AMP_MAX : req.amp;
		scaled  = 15'(req.data[6:0]) * 15'(amp_cap);
		ql      = div100(DIV_IN_W'(pl_s3));
		qr      = div100(DIV_IN_W'(pr_s3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// amplitude scale, sign with invert
		level_s1 <= scaled[13:7];
		neg_s1   <= req.data[7] ^ req.ctrl[4];
		pan_s1   <= req.ctrl[3:0];
		// segmented dac law
		mag_s2   <= dac_base(level_s1[6:4]) +
			13'(level_s1[3:0]) * 13'(dac_inc(level_s1[6:4]));
		neg_s2   <= neg_s1;
		pan_s2   <= pan_s1;
		// pan weights
		pl_s3    <= 20'(mag_s2) * 20'(pan_left(pan_s2));
		pr_s3    <= 20'(mag_s2) * 20'(pan_right(pan_s2));
		neg_s3   <= neg_s2;
		// divide magnitude, so truncation is toward zero
		left_s4  <= neg_s3 ? -CONTRIB_W'(ql) : CONTRIB_W'(ql);
		right_s4 <= neg_s3 ? -CONTRIB_W'(qr) : CONTRIB_W'(qr);
	end

	assign rsp.done  = v_s4;
	assign rsp.left  = left_s4;
	assign rsp.right = right_s4;

endmodule

`default_nettype wire

// ----- rtl/wavetable_synth_16ch.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sixteen-channel wavetable synthesiser behind a paged 8-bit host bus. Each command
// transaction is a bus write, a bus read or a tick; every one gives exactly one result
// transaction (read byte and hit flag, or a stereo frame after the tick for channel 15,
// otherwise zeros). Writing 0xfcff sets the page; with page bits 7..4 equal to 3, 0xfdxx
// reaches a 256-byte window of the 2 KiB wave memory picked by page bits 3..1. After
// reset the wave memory is swept to zero, one byte a cycle, and no command is taken
// until the sweep ends; config writes are taken at any time but only while idle do
// they follow the contract. Items are handled one at a time. A tick reads the six
// register-set bytes one per cycle through the single read port of the wave memory,
// then does the table fetch and runs the four-stage voice pipe. Results sit in an
// output register so the next command is taken while a result waits.
module wavetable_synth_16ch import wts_pkg::*; #(
	parameter int CHANNEL_COUNT = CHANNELS,
	parameter int MEMORY_BYTES  = MEM_BYTES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	wts_cmd_if.sink                   cmd,
	wts_rsp_if.source                 rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [VOL_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MEMORY_BYTES);
	localparam int CW = $clog2(CHANNEL_COUNT);
	localparam logic [2:0] FETCH_LAST = 3'd6;

	// register-set row for each fetch step: freq lo, mid, hi, waveform, amplitude, control
	function automatic logic [2:0] row_of(input logic [2:0] k);
		logic [2:0] r;
		unique case (k)
			3'd0:    r = 3'd0;
			3'd1:    r = 3'd1;
			3'd2:    r = 3'd2;
			3'd3:    r = 3'd5;
			3'd4:    r = 3'd6;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] sat16(input logic neg,
		input logic [DIV_OUT_W-1:0] q);
		logic [SAMPLE_W-1:0] v;
		if (!neg) begin
			v = (q > DIV_OUT_W'(32767)) ? 16'h7fff : q[15:0];
		end else begin
			v = (q > DIV_OUT_W'(32768)) ? 16'h8000 : (~q[15:0]) + 16'd1;
		end
		return v;
	endfunction

	state_t state_q, state_d;

	// configuration
	logic             enable_q;
	logic [VOL_W-1:0] volume_q;

	// block state
	logic [AW-1:0]            clr_cnt_q;
	logic [7:0]               page_q;
	logic [CW-1:0]            ch_q;
	logic                     alt_q;
	logic signed [MIX_W-1:0]  mix_l_q, mix_r_q;
	logic [CHANNEL_COUNT-1:0] phase_valid_q;

	// tick working registers
	logic [2:0]         fstep_q;
	logic [7:0]         flo_q, fmd_q, fhi_q, wave_q, amp_q, ctrl_q;
	logic               carry_q;
	logic [DIV_IN_W-1:0] fin_l_s1, fin_r_s1;
	logic               fin_lneg_s1, fin_rneg_s1;

	// result being built, and the output register
	logic                res_hit_q, res_frame_q;
	logic [BYTE_W-1:0]   res_rdata_q;
	logic [SAMPLE_W-1:0] res_left_q, res_right_q;
	logic                out_valid_q;
	logic                out_hit_q, out_frame_q;
	logic [BYTE_W-1:0]   out_rdata_q;
	logic [SAMPLE_W-1:0] out_left_q, out_right_q;

	// memory ports
	logic              w_we, w_re;
	logic [AW-1:0]     w_waddr, w_raddr;
	logic [7:0]        w_wdata, w_rdata;
	logic              p_we, p_re;
	logic [PHASE_W-1:0] p_rdata;

	voice_req_t voice_req;
	voice_rsp_t voice_rsp;

	// decode of the command transaction
	logic          accept, page_open, is_page, is_window, out_free, last_ch;
	logic [AW-1:0] win_off;
	logic [PHASE_W:0]   phase_sum;
	logic [PHASE_W-1:0] phase_old, phase_nx;
	logic [MIX_W-1:0]   mix_l_abs, mix_r_abs;

	assign accept    = cmd.valid && cmd.ready;
	assign page_open = (page_q[7:4] == PAGE_SEL_HI);
	assign is_page   = (cmd.address == PAGE_ADDR);
	assign is_window = page_open && (cmd.address[15:8] == WINDOW_HI);
	assign win_off   = AW'({page_q[3:1], cmd.address[7:0]});
	assign out_free  = !out_valid_q || rsp.ready;
	assign last_ch   = (ch_q == CW'(CHANNEL_COUNT - 1));

	// 24-bit phase step, bit 0 of freq low is the disable bit
	always_comb begin
		phase_old = phase_valid_q[ch_q] ? p_rdata : '0;
		phase_sum = (PHASE_W + 1)'(phase_old) + (PHASE_W + 1)'({fhi_q, fmd_q, flo_q[7:1], 1'b0});
		phase_nx  = flo_q[0] ? '0 : phase_sum[PHASE_W-1:0];
		mix_l_abs = mix_l_q[MIX_W-1] ? MIX_W'(-mix_l_q) : MIX_W'(mix_l_q);
		mix_r_abs = mix_r_q[MIX_W-1] ? MIX_W'(-mix_r_q) : MIX_W'(mix_r_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (!enable_q) begin
						state_d = S_RESULT;
					end else begin
						unique case (action_t'(cmd.action))
							ACT_READ: state_d = is_window ? S_RD : S_RESULT;
							ACT_TICK: state_d = S_FETCH;
							default:  state_d = S_RESULT;
						endcase
					end
				end
			end
			S_RD:    state_d = S_RESULT;
			S_FETCH: begin
				if (fstep_q == FETCH_LAST) state_d = S_PHASE;
			end
			S_PHASE: state_d = S_DATA;
			S_DATA:  state_d = S_VOICE;
			S_VOICE: begin
				if (voice_rsp.done) state_d = (ch_q == '0) ? S_FIN1 : S_RESULT;
			end
			S_FIN1:  state_d = S_FIN2;
			S_FIN2:  state_d = S_RESULT;
			S_RESULT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		cmd.ready       = (state_q == S_IDLE);
		w_we            = 1'b0;
		w_waddr         = win_off;
		w_wdata         = cmd.write_data;
		w_re            = 1'b0;
		w_raddr         = win_off;
		p_we            = 1'b0;
		p_re            = 1'b0;
		voice_req.start = (state_q == S_DATA);
		voice_req.data  = w_rdata;
		voice_req.amp   = amp_q;
		voice_req.ctrl  = ctrl_q;
		unique case (state_q)
			S_CLEAR: begin
				// power-on sweep of the wave memory
				w_we    = 1'b1;
				w_waddr = clr_cnt_q;
				w_wdata = '0;
			end
			S_IDLE: begin
				w_we = accept && enable_q && (action_t'(cmd.action) == ACT_WRITE) &&
					!is_page && is_window;
				w_re = accept && enable_q && (action_t'(cmd.action) == ACT_READ) && is_window;
			end
			S_FETCH: begin
				w_re    = (fstep_q != FETCH_LAST);
				w_raddr = AW'(SET_BASE) + AW'({alt_q, row_of(fstep_q), ch_q});
				p_re    = (fstep_q == 3'd0);
			end
			S_PHASE: begin
				// phase write-back and table fetch at the new phase
				p_we    = 1'b1;
				w_re    = 1'b1;
				w_raddr = AW'({wave_q[7:4], phase_nx[23:17]});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_cnt_q     <= '0;
			enable_q      <= 1'b0;
			volume_q      <= VOLUME_RESET;
			page_q        <= '0;
			ch_q          <= '0;
			alt_q         <= 1'b0;
			mix_l_q       <= '0;
			mix_r_q       <= '0;
			phase_valid_q <= '0;
			fstep_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_ENABLE: enable_q <= cfg_data[0];
					CFG_VOLUME: volume_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (accept && enable_q && (action_t'(cmd.action) == ACT_WRITE) && is_page) begin
				page_q <= cmd.write_data;
			end
			if (state_q == S_IDLE) fstep_q <= '0;
			else if (state_q == S_FETCH) fstep_q <= fstep_q + 3'd1;
			if (p_we) phase_valid_q[ch_q] <= 1'b1;
			if (state_q == S_DATA) begin
				// modulate selects the alternate set for the next channel
				ch_q  <= ch_q + CW'(1);
				alt_q <= last_ch ? 1'b0 :
					(ctrl_q[5] && (w_rdata[7] || carry_q));
			end
			if (state_q == S_VOICE && voice_rsp.done) begin
				mix_l_q <= mix_l_q + MIX_W'(voice_rsp.left);
				mix_r_q <= mix_r_q + MIX_W'(voice_rsp.right);
			end
			if (state_q == S_FIN1) begin
				mix_l_q <= '0;
				mix_r_q <= '0;
			end
			if (state_q == S_RESULT && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			res_rdata_q <= '0;
			res_hit_q   <= 1'b0;
			res_frame_q <= 1'b0;
			res_left_q  <= '0;
			res_right_q <= '0;
			if (enable_q && (action_t'(cmd.action) == ACT_READ) && page_open && is_page) begin
				res_rdata_q <= page_q;
				res_hit_q   <= 1'b1;
			end
		end
		if (state_q == S_RD) begin
			res_rdata_q <= w_rdata;
			res_hit_q   <= 1'b1;
		end
		if (state_q == S_FETCH) begin
			unique case (fstep_q)
				3'd1:    flo_q  <= w_rdata;
				3'd2:    fmd_q  <= w_rdata;
				3'd3:    fhi_q  <= w_rdata;
				3'd4:    wave_q <= w_rdata;
				3'd5:    amp_q  <= w_rdata;
				3'd6:    ctrl_q <= w_rdata;
				default: begin
				end
			endcase
		end
		if (state_q == S_PHASE) carry_q <= !flo_q[0] && phase_sum[PHASE_W];
		if (state_q == S_FIN1) begin
			fin_l_s1    <= DIV_IN_W'(mix_l_abs) * DIV_IN_W'(volume_q);
			fin_r_s1    <= DIV_IN_W'(mix_r_abs) * DIV_IN_W'(volume_q);
			fin_lneg_s1 <= mix_l_q[MIX_W-1];
			fin_rneg_s1 <= mix_r_q[MIX_W-1];
		end
		if (state_q == S_FIN2) begin
			res_frame_q <= 1'b1;
			res_left_q  <= sat16(fin_lneg_s1, div100(fin_l_s1));
			res_right_q <= sat16(fin_rneg_s1, div100(fin_r_s1));
		end
		if (state_q == S_RESULT && out_free) begin
			out_rdata_q <= res_rdata_q;
			out_hit_q   <= res_hit_q;
			out_frame_q <= res_frame_q;
			out_left_q  <= res_left_q;
			out_right_q <= res_right_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = out_rdata_q;
	assign rsp.read_hit    = out_hit_q;
	assign rsp.frame_valid = out_frame_q;
	assign rsp.left_out    = out_left_q;
	assign rsp.right_out   = out_right_q;

	// wave memory: tables, then normal and alternate register sets
	wts_ram #(
		.WIDTH (8),
		.DEPTH (MEMORY_BYTES)
	) u_wave_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// phase accumulators, read as zero until first written
	wts_ram #(
		.WIDTH (PHASE_W),
		.DEPTH (CHANNEL_COUNT)
	) u_phase_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (ch_q),
		.wdata (phase_nx),
		.re    (p_re),
		.raddr (ch_q),
		.rdata (p_rdata)
	);

	wts_voice u_voice (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (voice_req),
		.rsp    (voice_rsp)
	);

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("command taken while another is in flight");

	a_frame_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN1) |-> (ch_q == '0 && !alt_q))
		else $error("frame closed without channel wrap");

	a_mix_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN1) |=> (mix_l_q == '0 && mix_r_q == '0))
		else $error("mix not cleared after frame");

	a_voice_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		voice_rsp.done |-> (state_q == S_VOICE))
		else $error("voice result outside wait state");
`endif

endmodule

`default_nettype wire

// ----- tb/wavetable_synth_16ch_test.sv -----
`timescale 1ns / 1ps

module wavetable_synth_16ch_test import wts_pkg::*; ();

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 400;
	localparam int IDLE_LIMIT    = 20000; // well past the memory sweep after reset

	// the action code the block must treat as a no-op
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	// register-set layout: rows of 16 bytes, alternate set 0x80 above the normal one
	localparam int SET_STRIDE   = 'h80;
	localparam int OFS_FREQ_MID = 'h10;
	localparam int OFS_FREQ_HI  = 'h20;
	localparam int OFS_SHAPE    = 'h50;
	localparam int OFS_AMP      = 'h60;
	localparam int OFS_CTRL     = 'h70;
	localparam int SAMPLE_MAX   = 32767;
	localparam int SAMPLE_MIN   = -32768;

	typedef struct packed {
		logic [BYTE_W-1:0]          read_data;
		logic                       read_hit;
		logic                       frame_valid;
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
	} synth_result_t;

	// model of the synthesiser and the queue of results it still owes
	class synth_scoreboard;
		logic [BYTE_W-1:0]  wave_mem [MEM_BYTES];
		logic [PHASE_W-1:0] phase [CHANNELS];
		logic [7:0]         page;
		logic [3:0]         chan;
		logic               alt;
		int                 left_mix, right_mix;
		logic               enabled;
		logic [VOL_W-1:0]   volume;
		int                 pan_l [16];
		int                 pan_r [16];
		synth_result_t      results_due [$];
		int                 errors, commands, claimed_reads, frames, clipped_frames;

		function new();
			foreach (wave_mem[i]) wave_mem[i] = '0;
			foreach (phase[i]) phase[i] = '0;
			page = '0;
			chan = '0;
			alt = 1'b0;
			left_mix = 0;
			right_mix = 0;
			enabled = 1'b0;
			volume = VOLUME_RESET;
			pan_l = '{0, 0, 0, 0, 0, 0, 0, 0, 100, 100, 100, 83, 67, 50, 33, 17};
			pan_r = '{100, 100, 100, 100, 100, 100, 100, 100, 0, 0, 0, 17, 33, 50, 67, 83};
			errors = 0;
			commands = 0;
			claimed_reads = 0;
			frames = 0;
			clipped_frames = 0;
		endfunction

		function void write_register(cfg_index_t idx, logic [VOL_W-1:0] value);
			case (idx)
				CFG_ENABLE: enabled = value[0];
				CFG_VOLUME: volume = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		function logic signed [SAMPLE_W-1:0] clip16(int v);
			if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
			if (v < SAMPLE_MIN) return SAMPLE_W'(SAMPLE_MIN);
			return SAMPLE_W'(v);
		endfunction

		// one channel update; a frame comes out after channel 15
		function synth_result_t run_tick();
			synth_result_t res;
			int row;
			logic [7:0] lo_b, mid_b, hi_b, shape_b, amp_b, ctrl_b, wave_byte;
			int unsigned acc;
			logic carry, negative;
			int level, seg, sample;
			res = '0;
			row = SET_BASE + (alt ? SET_STRIDE : 0) + int'(chan);
			lo_b = wave_mem[row];
			mid_b = wave_mem[row + OFS_FREQ_MID];
			hi_b = wave_mem[row + OFS_FREQ_HI];
			shape_b = wave_mem[row + OFS_SHAPE];
			amp_b = wave_mem[row + OFS_AMP];
			ctrl_b = wave_mem[row + OFS_CTRL];
			carry = 1'b0;
			if (lo_b[0]) begin
				phase[chan] = '0;
			end else begin
				acc = phase[chan] + {hi_b, mid_b, lo_b[7:1], 1'b0};
				carry = acc[24];
				phase[chan] = acc[23:0];
			end
			wave_byte = wave_mem[{shape_b[7:4], phase[chan][23:17]}];
			negative = wave_byte[7];
			alt = ctrl_b[5] && (negative || carry);
			if (amp_b > AMP_MAX) amp_b = AMP_MAX;
			level = int'(wave_byte[6:0]) * int'(amp_b) / 128;
			seg = level / 16;
			// segment base is 33 * (2**seg - 1), step doubles per segment
			sample = 33 * ((1 << seg) - 1) + (level % 16) * (2 << seg);
			if (ctrl_b[4]) negative = !negative;
			if (negative) sample = -sample;
			left_mix += sample * pan_l[ctrl_b[3:0]] / 100;
			right_mix += sample * pan_r[ctrl_b[3:0]] / 100;
			chan = chan + 4'd1;
			if (chan == 4'd0) begin
				alt = 1'b0;
				res.frame_valid = 1'b1;
				res.left_out = clip16(left_mix * int'(volume) / 100);
				res.right_out = clip16(right_mix * int'(volume) / 100);
				left_mix = 0;
				right_mix = 0;
			end
			return res;
		endfunction

		function void note_command(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
				logic [BYTE_W-1:0] data);
			synth_result_t want;
			logic window_open;
			want = '0;
			window_open = (page[7:4] == PAGE_SEL_HI);
			commands++;
			if (enabled) begin
				case (act)
					ACT_WRITE: begin
						if (addr == PAGE_ADDR)
							page = data;
						else if (window_open && addr[15:8] == WINDOW_HI)
							wave_mem[{page[3:1], addr[7:0]}] = data;
					end
					ACT_READ: begin
						if (window_open && addr == PAGE_ADDR) begin
							want.read_data = page;
							want.read_hit = 1'b1;
						end else if (window_open && addr[15:8] == WINDOW_HI) begin
							want.read_data = wave_mem[{page[3:1], addr[7:0]}];
							want.read_hit = 1'b1;
						end
					end
					ACT_TICK: want = run_tick();
					default: ;
				endcase
			end
			if (want.read_hit) claimed_reads++;
			if (want.frame_valid) begin
				frames++;
				if (want.left_out == SAMPLE_W'(SAMPLE_MAX) || want.left_out == SAMPLE_W'(SAMPLE_MIN)
						|| want.right_out == SAMPLE_W'(SAMPLE_MAX)
						|| want.right_out == SAMPLE_W'(SAMPLE_MIN))
					clipped_frames++;
			end
			results_due.push_back(want);
		endfunction

		function void mismatch(string what, logic signed [31:0] want_v, logic signed [31:0] got_v);
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
		endfunction

		function void check_result(synth_result_t got);
			synth_result_t want;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding, expected none, got %h", $time, got);
				return;
			end
			want = results_due.pop_front();
			if (got.read_data !== want.read_data)
				mismatch("read_data", want.read_data, got.read_data);
			if (got.read_hit !== want.read_hit)
				mismatch("read_hit", want.read_hit, got.read_hit);
			if (got.frame_valid !== want.frame_valid)
				mismatch("frame_valid", want.frame_valid, got.frame_valid);
			if (got.left_out !== want.left_out)
				mismatch("left_out", want.left_out, got.left_out);
			if (got.right_out !== want.right_out)
				mismatch("right_out", want.right_out, got.right_out);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VOL_W-1:0]     cfg_data;

	wts_cmd_if cmd_ch ();
	wts_rsp_if rsp_ch ();

	wavetable_synth_16ch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	synth_scoreboard sb = new();

	// sender burst bookkeeping, receiver stall pattern and the long hold request
	int   burst_left = 0;
	int   items_sent = 0;
	int   settings_seen = 0;
	int   idle_cycles = 0;
	int   hold_left = 0;
	int   run_left = 0;
	logic run_open = 1'b0;
	logic want_hold = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: open and stalled runs of random length, now and then a long open run;
	// a long hold is counted out here once the stimulus asks for it
	always @(negedge clk) begin
		if (want_hold) begin
			want_hold = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			if (run_left == 0) begin
				run_open = !run_open;
				if (run_open)
					run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 12);
				else
					run_left = $urandom_range(1, 6);
			end
			run_left--;
			rsp_ch.ready <= run_open;
		end
	end

	// transactions seen at the rising edge feed the scoreboard; the watchdog counts
	// cycles in which nothing moves on either channel or the register port
	always @(posedge clk) begin : observe
		synth_result_t seen;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_command(cmd_ch.action, cmd_ch.address, cmd_ch.write_data);
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.read_data = rsp_ch.read_data;
				seen.read_hit = rsp_ch.read_hit;
				seen.frame_valid = rsp_ch.frame_valid;
				seen.left_out = rsp_ch.left_out;
				seen.right_out = rsp_ch.right_out;
				sb.check_result(seen);
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, idle_cycles, sb.pending());
				$display("wavetable_synth_16ch verification failed");
				$finish;
			end
		end
	end

	// one command transaction; valid stays up across a burst and drops for the gaps
	// between bursts. returns just after the accepting edge, before any later posedge
	task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] data);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.address <= addr;
		cmd_ch.write_data <= data;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
	endtask

	// stop offering and let every outstanding result come back, then let the block settle
	task automatic wait_drained();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register writes happen only with no command in flight, so the model is updated at once
	task automatic write_reg(input cfg_index_t idx, input logic [VOL_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_register(idx, value);
		settings_seen++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// well-formed use: select a window, load some bytes, then tick through a frame
	// (sometimes only part of one) with the odd read mixed in
	task automatic play_sequence();
		logic [2:0] win;
		logic [7:0] spot, data;
		int writes, ticks;
		// window 7 holds both register sets, the others hold two wave tables each
		win = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'($urandom_range(0, 6));
		send_cmd(ACT_WRITE, PAGE_ADDR, {PAGE_SEL_HI, win, 1'($urandom)});
		spot = 8'($urandom);
		writes = $urandom_range(2, 14);
		repeat (writes) begin
			data = 8'($urandom);
			// lean amplitudes towards the cap so frames get loud enough to clip
			if (win == 3'd7 && spot[6:4] == 3'(OFS_AMP >> 4) && $urandom_range(0, 1) != 0)
				data = 8'($urandom_range(128, 255));
			send_cmd(ACT_WRITE, {WINDOW_HI, spot}, data);
			// tables are filled in runs, register bytes are scattered
			spot = (win == 3'd7) ? 8'($urandom) : spot + 8'd1;
		end
		ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : CHANNELS;
		repeat (ticks) begin
			if ($urandom_range(0, 11) == 0)
				send_cmd(ACT_READ, {WINDOW_HI, 8'($urandom)}, 8'($urandom));
			send_cmd(ACT_TICK, 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic random_commands(input int count);
		int stop_at, pick, reads;
		logic [ADDR_W-1:0] addr;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				play_sequence();
			end else if (pick < 75) begin
				reads = $urandom_range(1, 4);
				repeat (reads) begin
					addr = ($urandom_range(0, 4) == 0) ? PAGE_ADDR : {WINDOW_HI, 8'($urandom)};
					send_cmd(ACT_READ, addr, 8'($urandom));
				end
			end else begin
				// noise: any action, page register, window or anywhere at all
				case ($urandom_range(0, 2))
					0: addr = PAGE_ADDR;
					1: addr = {WINDOW_HI, 8'($urandom)};
					default: addr = 16'($urandom);
				endcase
				send_cmd(ACT_ACTION_RANDOM(), addr, 8'($urandom));
			end
		end
	endtask

	function automatic logic [ACTION_W-1:0] ACT_ACTION_RANDOM();
		return ACTION_W'($urandom_range(0, 3));
	endfunction

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_WRITE;
		cmd_ch.address = '0;
		cmd_ch.write_data = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// commands are held off by the memory sweep; register writes are not
		write_reg(CFG_ENABLE, 7'd1);
		write_reg(CFG_VOLUME, VOLUME_RESET);

		// directed: page register closed then open, channel 0 set up loud on table
		// fifteen (register bytes as wave data) with amplitude over the cap, mostly right
		// pan, invert and modulate; alternate channel 1 disabled; last window byte;
		// the unused action; an unmapped read; then a full frame of ticks
		send_cmd(ACT_READ, PAGE_ADDR, 8'h00);
		send_cmd(ACT_WRITE, PAGE_ADDR, 8'h3e);
		send_cmd(ACT_READ, PAGE_ADDR, 8'h00);
		send_cmd(ACT_WRITE, {WINDOW_HI, 8'(OFS_FREQ_HI)}, 8'hff);
		send_cmd(ACT_WRITE, {WINDOW_HI, 8'(OFS_SHAPE)}, 8'hf0);
		send_cmd(ACT_WRITE, {WINDOW_HI, 8'(OFS_AMP)}, 8'hff);
		send_cmd(ACT_WRITE, {WINDOW_HI, 8'(OFS_CTRL)}, 8'h3f);
		send_cmd(ACT_WRITE, {WINDOW_HI, 8'(SET_STRIDE + 1)}, 8'h01);
		send_cmd(ACT_WRITE, {WINDOW_HI, 8'hff}, 8'hff);
		send_cmd(ACT_READ, {WINDOW_HI, 8'hff}, 8'h00);
		send_cmd(ACT_UNUSED, PAGE_ADDR, 8'h5a);
		send_cmd(ACT_READ, 16'hffff, 8'h00);
		repeat (CHANNELS) send_cmd(ACT_TICK, 16'h0000, 8'h00);

		random_commands(300);

		// loudest volume, frames clip
		wait_drained();
		write_reg(CFG_VOLUME, 7'd127);
		random_commands(250);

		// silent volume
		wait_drained();
		write_reg(CFG_VOLUME, 7'd0);
		random_commands(150);

		// disabled block: everything ignored, volume change parked meanwhile
		wait_drained();
		write_reg(CFG_ENABLE, 7'd0);
		write_reg(CFG_VOLUME, 7'd63);
		random_commands(40);

		wait_drained();
		write_reg(CFG_ENABLE, 7'd1);
		random_commands(230);

		// back to unity; receiver holds off while the sender keeps offering, then the
		// sender pauses until the block is empty
		wait_drained();
		write_reg(CFG_VOLUME, VOLUME_RESET);
		random_commands(150);
		want_hold = 1'b1;
		random_commands(80);
		wait_drained();
		random_commands(140);

		wait_drained();
		$display("%0d commands over %0d register writes: %0d claimed reads, %0d frames",
			sb.commands, settings_seen, sb.claimed_reads, sb.frames);
		$display("%0d frames clipped, %0d mismatches", sb.clipped_frames, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("wavetable_synth_16ch verification clean");
		else
			$display("wavetable_synth_16ch verification failed");
		$finish;
	end

endmodule
